@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, cond, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif

`endif

@@ hw/rtl/ssmi_pkg.sv @@
// shared constants, codes and types of the servo move interpolator
package ssmi_pkg;

    localparam int SERVOS     = 4;
    localparam int ANGLE_W    = 17;
    localparam int DELTA_W    = 18;
    localparam int PULSE_W    = 12;
    localparam int SPEED_W    = 15;
    localparam int HOLD_W     = 16;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MD_W     = 17;
    localparam int MD_CNT_W = 5;

    localparam int S_DATA_W = ((SERVOS * ANGLE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SERVOS * PULSE_W + 7) / 8) * 8;
    localparam int M_USER_W = PHASE_W + 1;

    localparam logic [MD_W-1:0] FULL_SCALE = MD_W'(18000);

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PLACE = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MOVE = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd3;

    typedef struct packed {
        logic [MD_W-1:0] a;
        logic [MD_W-1:0] b;
        logic [MD_W-1:0] d;
    } md_req_t;

    function automatic logic signed [ANGLE_W-1:0] reset_angle(input int unsigned idx);
        logic signed [ANGLE_W-1:0] r;
        case (idx) inside
            0, 1:    r = ANGLE_W'(9000);
            3:       r = ANGLE_W'(18000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/ssmi_muldiv.sv @@
// bit-serial multiply then restoring divide: quot = (a * b) / d
`include "assert_macros.svh"

module ssmi_muldiv import ssmi_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  md_req_t         req,
    output logic            done,
    output logic [MD_W-1:0] quot
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } md_state_t;

    localparam logic [MD_CNT_W-1:0] CNT_LAST = MD_CNT_W'(MD_W - 1);

    md_state_t             st_reg, st_next;
    logic [MD_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [MD_W-1:0]       a_reg, a_next;
    logic [MD_W-1:0]       d_reg, d_next;
    logic [2*MD_W:0]       p_reg, p_next;

    always_comb begin
        logic [MD_W:0] sum;
        logic [MD_W:0] part;
        logic          ge;
        logic [MD_W:0] rem;

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        d_next    = d_reg;
        p_next    = p_reg;

        sum  = p_reg[2*MD_W:MD_W] + (p_reg[0] ? {1'b0, a_reg} : '0);
        part = {p_reg[2*MD_W-1:MD_W], p_reg[MD_W-1]};
        ge   = part >= {1'b0, d_reg};
        rem  = ge ? part - {1'b0, d_reg} : part;

        case (st_reg)
            U_IDLE: begin
                if (start) begin
                    a_next   = req.a;
                    d_next   = req.d;
                    p_next   = {{(MD_W + 1){1'b0}}, req.b};
                    cnt_next = '0;
                    st_next  = U_MUL;
                end
            end
            U_MUL: begin
                // add a when the current multiplier bit is set, then shift right
                p_next   = {sum, p_reg[MD_W-1:0]} >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next = '0;
                    st_next  = U_DIV;
                end
            end
            U_DIV: begin
                // one quotient bit per cycle shifts in at the bottom
                p_next   = {1'b0, rem[MD_W-1:0], p_reg[MD_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next  = '0;
                    done_next = 1'b1;
                    st_next   = U_IDLE;
                end
            end
            default: begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= U_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        d_reg <= d_next;
        p_reg <= p_next;
    end

    assign done = done_reg;
    assign quot = p_reg[MD_W-1:0];

    `ASSERT_IMPLY(a_start_idle, aclk, aresetn, start, st_reg == U_IDLE, "start while busy")
    `ASSERT_NEXT(a_mul_to_div, aclk, aresetn, (st_reg == U_MUL) && (cnt_reg == CNT_LAST), st_reg == U_DIV, "multiply did not hand over to divide")
    `ASSERT_IMPLY(a_rem_bound, aclk, aresetn, done_reg, p_reg[2*MD_W-1:MD_W] < d_reg, "remainder not below divisor")
    `ASSERT_IMPLY(a_done_idle, aclk, aresetn, done_reg, st_reg == U_IDLE, "done while still running")

endmodule

@@ hw/rtl/servo_sync_move_interpolator_unit.sv @@
// top level of the synchronized multi-axis servo move interpolator
//
// Each input beat is a tick, a move or a place command; each one returns one result beat with
// the commanded pulse width of every axis, the motion phase and an accepted flag. Every axis
// has its own bit-serial multiply/divide unit that works one bit per cycle: a beat that leaves
// the block moving goes through the interpolated angle and then the pulse mapping, each a
// multiply and divide in the serial unit, while any other beat goes through the pulse mapping
// only. A new beat is taken while the previous result still
// waits in the output register. Configuration writes are always taken and must only be made
// while the block is idle.
`include "assert_macros.svh"

module servo_sync_move_interpolator_unit import ssmi_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // target_0, target_1, ... target_N, zero fill
    input  logic [MODE_W-1:0]     s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // pulse_0, pulse_1, ... pulse_N
    output logic [M_USER_W-1:0]   m_tuser,   // phase, accepted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        SEQ_IDLE    = 6'b000001,
        SEQ_ANG_GO  = 6'b000010,
        SEQ_ANG_RUN = 6'b000100,
        SEQ_PUL_GO  = 6'b001000,
        SEQ_PUL_RUN = 6'b010000,
        SEQ_EMIT    = 6'b100000
    } seq_state_t;

    logic [PULSE_W-1:0]        pmin_reg, pmin_next;
    logic [PULSE_W-1:0]        pmax_reg, pmax_next;
    logic [SPEED_W-1:0]        speed_reg, speed_next;
    logic [HOLD_W-1:0]         hticks_reg, hticks_next;

    logic signed [ANGLE_W-1:0] start_reg [SERVOS];
    logic signed [ANGLE_W-1:0] start_next [SERVOS];
    logic signed [ANGLE_W-1:0] goal_reg [SERVOS];
    logic signed [ANGLE_W-1:0] goal_next [SERVOS];
    logic signed [DELTA_W-1:0] delta_reg [SERVOS];
    logic signed [DELTA_W-1:0] delta_next [SERVOS];
    logic signed [ANGLE_W-1:0] angle_reg [SERVOS];
    logic signed [ANGLE_W-1:0] angle_next [SERVOS];
    logic [PULSE_W-1:0]        pulse_reg [SERVOS];
    logic [PULSE_W-1:0]        pulse_next [SERVOS];

    logic [ANGLE_W-1:0]        largest_reg, largest_next;
    logic [ANGLE_W-1:0]        run_reg, run_next;
    logic [HOLD_W-1:0]         hold_reg, hold_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic                      acc_reg, acc_next;
    seq_state_t                seq_reg, seq_next;

    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;
    logic [M_USER_W-1:0]       m_user_reg, m_user_next;

    md_req_t                   md_req [SERVOS];
    logic [SERVOS-1:0]         md_done;
    logic [MD_W-1:0]           md_quot [SERVOS];
    logic                      md_start;
    logic                      moving;
    logic                      done_all;
    logic                      s_accept;
    logic                      cfg_accept;
    logic signed [PULSE_W:0]   span;
    logic                      span_neg;
    logic [PULSE_W:0]          span_mag;

    assign s_tready   = (seq_reg == SEQ_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign moving     = (phase_reg == PH_MOVE) && (largest_reg != '0);
    assign done_all   = &md_done;
    assign md_start   = ((seq_reg == SEQ_ANG_GO) && moving) || (seq_reg == SEQ_PUL_GO);

    assign span     = $signed({1'b0, pmax_reg}) - $signed({1'b0, pmin_reg});
    assign span_neg = span[PULSE_W];
    assign span_mag = span_neg ? PULSE_W'(0) - span : span;

    // operands for the per-axis serial units
    always_comb begin
        logic [DELTA_W-1:0] mag;
        logic [MD_W-1:0]    clamp;
        for (int i = 0; i < SERVOS; i++) begin
            mag = delta_reg[i][DELTA_W-1] ? DELTA_W'(-delta_reg[i]) : delta_reg[i];
            if (angle_reg[i][ANGLE_W-1]) begin
                clamp = '0;
            end else if ($unsigned(angle_reg[i]) > FULL_SCALE) begin
                clamp = FULL_SCALE;
            end else begin
                clamp = $unsigned(angle_reg[i]);
            end
            if (seq_reg == SEQ_ANG_GO) begin
                md_req[i].a = mag[MD_W-1:0];
                md_req[i].b = run_reg;
                md_req[i].d = largest_reg;
            end else begin
                md_req[i].a = clamp;
                md_req[i].b = {{(MD_W - PULSE_W){1'b0}}, span_mag[PULSE_W-1:0]};
                md_req[i].d = FULL_SCALE;
            end
        end
    end

    for (genvar gi = 0; gi < SERVOS; gi++) begin : g_lane
        ssmi_muldiv u_md (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (md_start),
            .req     (md_req[gi]),
            .done    (md_done[gi]),
            .quot    (md_quot[gi])
        );
    end

    always_comb begin
        logic signed [DELTA_W-1:0] tgt;
        logic signed [DELTA_W-1:0] dif;
        logic [DELTA_W-1:0]        dmag;
        logic [ANGLE_W-1:0]        big;
        logic [DELTA_W-1:0]        run_step;
        logic [SPEED_W-1:0]        eff_speed;
        logic [HOLD_W-1:0]         hold_dec;
        logic signed [DELTA_W:0]   ang_sum;
        logic [PULSE_W+1:0]        pul_sum;
        logic [PULSE_W+1:0]        q_ext;

        pmin_next    = pmin_reg;
        pmax_next    = pmax_reg;
        speed_next   = speed_reg;
        hticks_next  = hticks_reg;
        largest_next = largest_reg;
        run_next     = run_reg;
        hold_next    = hold_reg;
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        seq_next     = seq_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        for (int i = 0; i < SERVOS; i++) begin
            start_next[i] = start_reg[i];
            goal_next[i]  = goal_reg[i];
            delta_next[i] = delta_reg[i];
            angle_next[i] = angle_reg[i];
            pulse_next[i] = pulse_reg[i];
        end

        eff_speed = (speed_reg == '0) ? SPEED_W'(1) : speed_reg;
        run_step  = {1'b0, run_reg} + {{(DELTA_W - SPEED_W){1'b0}}, eff_speed};
        hold_dec  = (hold_reg == '0) ? '0 : hold_reg - 1'b1;

        big = '0;
        for (int i = 0; i < SERVOS; i++) begin
            tgt  = {s_tdata[i*ANGLE_W + ANGLE_W - 1], s_tdata[i*ANGLE_W +: ANGLE_W]};
            dif  = tgt - {start_reg[i][ANGLE_W-1], start_reg[i]};
            dmag = dif[DELTA_W-1] ? DELTA_W'(-dif) : dif;
            if (dmag[ANGLE_W-1:0] > big) begin
                big = dmag[ANGLE_W-1:0];
            end
        end

        if (cfg_accept) begin
            case (cfg_index)
                REG_PULSE_MIN: pmin_next   = cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX: pmax_next   = cfg_data[PULSE_W-1:0];
                REG_SPEED:     speed_next  = cfg_data[SPEED_W-1:0];
                REG_HOLD:      hticks_next = cfg_data[HOLD_W-1:0];
                default:       ;
            endcase
        end

        case (seq_reg)
            SEQ_IDLE: begin
                if (s_accept) begin
                    acc_next = 1'b0;
                    seq_next = SEQ_ANG_GO;
                    case (s_tuser)
                        MODE_TICK: begin
                            if (phase_reg == PH_MOVE) begin
                                if (run_step > {1'b0, largest_reg}) begin
                                    for (int i = 0; i < SERVOS; i++) begin
                                        start_next[i] = goal_reg[i];
                                    end
                                    hold_next  = hticks_reg;
                                    phase_next = (hticks_reg == '0) ? PH_IDLE : PH_HOLD;
                                end else begin
                                    run_next = run_step[ANGLE_W-1:0];
                                end
                            end else if (phase_reg == PH_HOLD) begin
                                hold_next = hold_dec;
                                if (hold_dec == '0) begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        MODE_MOVE: begin
                            if (phase_reg == PH_IDLE) begin
                                acc_next = 1'b1;
                                if (big != '0) begin
                                    for (int i = 0; i < SERVOS; i++) begin
                                        tgt = {s_tdata[i*ANGLE_W + ANGLE_W - 1],
                                               s_tdata[i*ANGLE_W +: ANGLE_W]};
                                        goal_next[i]  = tgt[ANGLE_W-1:0];
                                        delta_next[i] = tgt - {start_reg[i][ANGLE_W-1],
                                                               start_reg[i]};
                                    end
                                    largest_next = big;
                                    run_next     = '0;
                                    phase_next   = PH_MOVE;
                                end
                            end
                        end
                        MODE_PLACE: begin
                            if (phase_reg == PH_IDLE) begin
                                acc_next = 1'b1;
                                for (int i = 0; i < SERVOS; i++) begin
                                    goal_next[i]  = s_tdata[i*ANGLE_W +: ANGLE_W];
                                    start_next[i] = s_tdata[i*ANGLE_W +: ANGLE_W];
                                end
                                hold_next  = hticks_reg;
                                phase_next = (hticks_reg == '0) ? PH_IDLE : PH_HOLD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            SEQ_ANG_GO: begin
                if (moving) begin
                    seq_next = SEQ_ANG_RUN;
                end else begin
                    for (int i = 0; i < SERVOS; i++) begin
                        angle_next[i] = start_reg[i];
                    end
                    seq_next = SEQ_PUL_GO;
                end
            end
            SEQ_ANG_RUN: begin
                if (done_all) begin
                    for (int i = 0; i < SERVOS; i++) begin
                        ang_sum = {{2{start_reg[i][ANGLE_W-1]}}, start_reg[i]};
                        if (delta_reg[i][DELTA_W-1]) begin
                            ang_sum = ang_sum - $signed({2'b00, md_quot[i]});
                        end else begin
                            ang_sum = ang_sum + $signed({2'b00, md_quot[i]});
                        end
                        angle_next[i] = ang_sum[ANGLE_W-1:0];
                    end
                    seq_next = SEQ_PUL_GO;
                end
            end
            SEQ_PUL_GO: begin
                seq_next = SEQ_PUL_RUN;
            end
            SEQ_PUL_RUN: begin
                if (done_all) begin
                    for (int i = 0; i < SERVOS; i++) begin
                        q_ext   = {2'b00, md_quot[i][PULSE_W-1:0]};
                        pul_sum = span_neg ? {2'b00, pmin_reg} - q_ext
                                           : {2'b00, pmin_reg} + q_ext;
                        pulse_next[i] = pul_sum[PULSE_W-1:0];
                    end
                    seq_next = SEQ_EMIT;
                end
            end
            SEQ_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next = '0;
                    for (int i = 0; i < SERVOS; i++) begin
                        m_data_next[i*PULSE_W +: PULSE_W] = pulse_reg[i];
                    end
                    m_user_next  = {acc_reg, phase_reg};
                    m_valid_next = 1'b1;
                    seq_next     = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pmin_reg    <= PULSE_W'(500);
            pmax_reg    <= PULSE_W'(2500);
            speed_reg   <= SPEED_W'(10);
            hticks_reg  <= HOLD_W'(500);
            largest_reg <= '0;
            run_reg     <= '0;
            hold_reg    <= '0;
            phase_reg   <= PH_IDLE;
            acc_reg     <= 1'b0;
            seq_reg     <= SEQ_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SERVOS; i++) begin
                start_reg[i] <= reset_angle(i);
                goal_reg[i]  <= '0;
                delta_reg[i] <= '0;
            end
        end else begin
            pmin_reg    <= pmin_next;
            pmax_reg    <= pmax_next;
            speed_reg   <= speed_next;
            hticks_reg  <= hticks_next;
            largest_reg <= largest_next;
            run_reg     <= run_next;
            hold_reg    <= hold_next;
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < SERVOS; i++) begin
                start_reg[i] <= start_next[i];
                goal_reg[i]  <= goal_next[i];
                delta_reg[i] <= delta_next[i];
            end
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        for (int i = 0; i < SERVOS; i++) begin
            angle_reg[i] <= angle_next[i];
            pulse_reg[i] <= pulse_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_IMPLY(a_move_nonzero, aclk, aresetn, phase_reg == PH_MOVE, largest_reg != '0, "moving with zero largest delta")
    `ASSERT_IMPLY(a_run_bound, aclk, aresetn, phase_reg == PH_MOVE, run_reg <= largest_reg, "progress beyond largest delta")
    `ASSERT_IMPLY(a_hold_left, aclk, aresetn, phase_reg == PH_HOLD, hold_reg != '0, "holding with no ticks left")
    `ASSERT_IMPLY(a_lanes_together, aclk, aresetn, |md_done, &md_done, "axis units out of step")

endmodule

@@ tb/sv/tb_servo_sync_move_interpolator_unit.sv @@
// self-checking testbench for the synchronized servo move interpolator, with a cycle-free predictor
`timescale 1ns / 100ps

module tb_servo_sync_move_interpolator_unit;
    import ssmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int ANGLE_LIMIT    = 36000;
    localparam int PHASE_BEATS    = 160;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [PULSE_W-1:0]             pmin;
        logic [PULSE_W-1:0]             pmax;
        logic [SPEED_W-1:0]             speed;
        logic [HOLD_W-1:0]              hold;
        logic [SERVOS-1:0][ANGLE_W-1:0] start;
        logic [SERVOS-1:0][ANGLE_W-1:0] goal;
        logic [SERVOS-1:0][DELTA_W-1:0] delta;
        logic [ANGLE_W-1:0]             largest;
        logic [ANGLE_W-1:0]             elapsed;
        logic [HOLD_W-1:0]              hold_left;
        logic [PHASE_W-1:0]             phase;
    } servo_state_t;

    typedef struct packed {
        logic [SERVOS-1:0][PULSE_W-1:0] pulse;
        logic [PHASE_W-1:0]             phase;
        logic                           accepted;
    } servo_result_t;

    typedef struct packed {
        logic                           is_cfg;
        logic [MODE_W-1:0]              mode;
        logic [SERVOS-1:0][ANGLE_W-1:0] target;
        logic [CFG_IDX_W-1:0]           index;
        logic [CFG_DATA_W-1:0]          data;
    } stim_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;    // target_0, target_1, target_2, target_3, zero fill
    logic [MODE_W-1:0]     s_tuser   = MODE_TICK;  // mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;           // pulse_0, pulse_1, pulse_2, pulse_3
    logic [M_USER_W-1:0]   m_tuser;           // phase, accepted
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PULSE_MIN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    servo_state_t  model_st;
    servo_state_t  plan_st;
    servo_result_t expected_q[$];
    stim_item_t    stim_q[$];
    stim_item_t    drive_item;

    int results_owed   = 0;
    int writes_owed    = 0;
    int err_cnt        = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_items    = 0;

    servo_sync_move_interpolator_unit DUT (.*);

    always #2 aclk = ~aclk;

    function automatic servo_state_t servo_reset_state();
        servo_state_t st;
        st       = '0;
        st.pmin  = PULSE_W'(500);
        st.pmax  = PULSE_W'(2500);
        st.speed = SPEED_W'(10);
        st.hold  = HOLD_W'(500);
        for (int i = 0; i < SERVOS; i++) begin
            st.start[i] = (i < 2) ? ANGLE_W'(9000) : ((i == 3) ? ANGLE_W'(18000) : '0);
        end
        st.phase = PH_IDLE;
        return st;
    endfunction

    function automatic longint move_speed(input servo_state_t st);
        return (st.speed == '0) ? 64'sd1 : longint'(st.speed);
    endfunction

    task automatic enter_hold(inout servo_state_t st);
        st.start     = st.goal;
        st.hold_left = st.hold;
        st.phase     = (st.hold == '0) ? PH_IDLE : PH_HOLD;
    endtask

    task automatic servo_config(inout servo_state_t st, input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PULSE_MIN: st.pmin  = val[PULSE_W-1:0];
            REG_PULSE_MAX: st.pmax  = val[PULSE_W-1:0];
            REG_SPEED:     st.speed = val[SPEED_W-1:0];
            REG_HOLD:      st.hold  = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic servo_step(inout servo_state_t st, input logic [MODE_W-1:0] mode,
                              input logic [SERVOS-1:0][ANGLE_W-1:0] target,
                              output servo_result_t res);
        longint diff;
        longint biggest;
        longint ang;
        longint span;
        logic   took;
        took = 1'b0;
        case (mode)
            MODE_TICK: begin
                if (st.phase == PH_MOVE) begin
                    if ((longint'(st.elapsed) + 1) * move_speed(st) > longint'(st.largest))
                        enter_hold(st);
                    else
                        st.elapsed = st.elapsed + 1'b1;
                end else if (st.phase == PH_HOLD) begin
                    if (st.hold_left != '0) st.hold_left = st.hold_left - 1'b1;
                    if (st.hold_left == '0) st.phase = PH_IDLE;
                end
            end
            MODE_MOVE, MODE_PLACE: begin
                if (st.phase == PH_IDLE) begin
                    took = 1'b1;
                    if (mode == MODE_MOVE) begin
                        biggest = 0;
                        for (int i = 0; i < SERVOS; i++) begin
                            diff = longint'($signed(target[i])) - longint'($signed(st.start[i]));
                            if (diff < 0) diff = -diff;
                            if (diff > biggest) biggest = diff;
                        end
                        if (biggest != 0) begin
                            for (int i = 0; i < SERVOS; i++) begin
                                st.goal[i]  = target[i];
                                st.delta[i] = DELTA_W'(longint'($signed(target[i]))
                                              - longint'($signed(st.start[i])));
                            end
                            st.largest = ANGLE_W'(biggest);
                            st.elapsed = '0;
                            st.phase   = PH_MOVE;
                        end
                    end else begin
                        st.goal = target;
                        enter_hold(st);
                    end
                end
            end
            default: ;
        endcase
        span = longint'(st.pmax) - longint'(st.pmin);
        for (int i = 0; i < SERVOS; i++) begin
            ang = longint'($signed(st.start[i]));
            if (st.phase == PH_MOVE && st.largest != '0)
                ang = ang + (longint'($signed(st.delta[i])) * longint'(st.elapsed)
                      * move_speed(st)) / longint'(st.largest);
            if (ang < 0) ang = 0;
            else if (ang > longint'(FULL_SCALE)) ang = longint'(FULL_SCALE);
            res.pulse[i] = PULSE_W'(longint'(st.pmin) + (ang * span) / longint'(FULL_SCALE));
        end
        res.phase    = st.phase;
        res.accepted = took;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_cnt++;
    endtask

    function automatic logic [SERVOS-1:0][ANGLE_W-1:0] angles4(input int a0, a1, a2, a3);
        logic [SERVOS-1:0][ANGLE_W-1:0] t;
        t[0] = ANGLE_W'(a0);
        t[1] = ANGLE_W'(a1);
        t[2] = ANGLE_W'(a2);
        t[3] = ANGLE_W'(a3);
        return t;
    endfunction

    function automatic logic [SERVOS-1:0][ANGLE_W-1:0] any_targets();
        logic [SERVOS-1:0][ANGLE_W-1:0] t;
        for (int i = 0; i < SERVOS; i++) begin
            t[i] = ANGLE_W'(int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT);
        end
        return t;
    endfunction

    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [SERVOS-1:0][ANGLE_W-1:0] target);
        stim_item_t    it;
        servo_result_t ignored;
        servo_step(plan_st, mode, target, ignored);
        it        = '0;
        it.mode   = mode;
        it.target = target;
        stim_q.push_back(it);
        results_owed++;
        phase_items++;
    endtask

    task automatic send_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_item_t it;
        it        = '0;
        it.is_cfg = 1'b1;
        it.index  = idx;
        it.data   = CFG_DATA_W'(val);
        servo_config(plan_st, it.index, it.data);
        stim_q.push_back(it);
        writes_owed++;
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (stim_q.size() != 0 || results_owed != 0 || writes_owed != 0);
    endtask

    task automatic finish_motion();
        while (plan_st.phase != PH_IDLE) send_beat(MODE_TICK, any_targets());
    endtask

    task automatic settle_and_write(input int pmin, input int pmax, input int spd, input int hold);
        finish_motion();
        wait_drained();
        send_write(REG_PULSE_MIN, pmin);
        send_write(REG_PULSE_MAX, pmax);
        send_write(REG_SPEED, spd);
        send_write(REG_HOLD, hold);
    endtask

    always @(posedge aclk) begin : stim_driver
        logic          next_s;
        logic          next_c;
        servo_result_t res;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            next_s = s_tvalid && !s_tready;
            next_c = cfg_valid && !cfg_ready;
            if (s_tvalid && s_tready) begin
                servo_step(model_st, drive_item.mode, drive_item.target, res);
                expected_q.push_back(res);
            end
            if (cfg_valid && cfg_ready) begin
                servo_config(model_st, drive_item.index, drive_item.data);
                writes_owed--;
            end
            if (!next_s && !next_c && stim_q.size() != 0) begin
                if (stim_q[0].is_cfg) begin
                    drive_item = stim_q.pop_front();
                    cfg_index <= drive_item.index;
                    cfg_data  <= drive_item.data;
                    next_c = 1'b1;
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    drive_item = stim_q.pop_front();
                    s_tdata <= S_DATA_W'(drive_item.target);
                    s_tuser <= drive_item.mode;
                    next_s = 1'b1;
                end
            end
            s_tvalid  <= next_s;
            cfg_valid <= next_c;
        end
    end

    always @(posedge aclk) begin : result_monitor
        servo_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("beat with nothing expected", m_tuser, 0);
                end else begin
                    want = expected_q.pop_front();
                    results_owed--;
                    for (int i = 0; i < SERVOS; i++) begin
                        if (m_tdata[i*PULSE_W +: PULSE_W] !== want.pulse[i])
                            report_mismatch($sformatf("pulse_%0d", i),
                                            m_tdata[i*PULSE_W +: PULSE_W], want.pulse[i]);
                    end
                    if (m_tuser[PHASE_W-1:0] !== want.phase)
                        report_mismatch("phase", m_tuser[PHASE_W-1:0], want.phase);
                    if (m_tuser[PHASE_W] !== want.accepted)
                        report_mismatch("accepted", m_tuser[PHASE_W], want.accepted);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int   pick;
        int   reach;
        int   cut;
        int   steps;
        int   aim;
        int   spd;
        logic paused;
        logic [SERVOS-1:0][ANGLE_W-1:0] tgt;
        model_st = servo_reset_state();
        plan_st  = servo_reset_state();
        paused   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: idle behavior only
        send_beat(MODE_TICK, any_targets());
        send_beat(MODE_UNUSED, any_targets());
        send_beat(MODE_MOVE, plan_st.start);

        // full pulse range, fastest speed, no hold
        settle_and_write(0, 4000, 18000, 0);
        send_beat(MODE_PLACE, angles4(36000, -36000, 18001, -1));
        send_beat(MODE_MOVE, angles4(-36000, 36000, 0, 18000));
        send_beat(MODE_MOVE, any_targets());
        send_beat(MODE_PLACE, any_targets());
        send_beat(MODE_UNUSED, any_targets());
        finish_motion();
        send_beat(MODE_MOVE, plan_st.start);
        send_beat(MODE_TICK, any_targets());

        // reversed pulse range, zero speed register
        settle_and_write(4000, 0, 0, 2);
        send_beat(MODE_PLACE, angles4(9000, 0, 18000, 4500));
        send_beat(MODE_MOVE, any_targets());
        finish_motion();
        send_beat(MODE_MOVE, angles4(9003, -2, 17995, 4500));
        send_beat(MODE_PLACE, any_targets());
        finish_motion();

        // flat pulse range
        settle_and_write(4000, 4000, 17999, 0);
        send_beat(MODE_MOVE, any_targets());
        finish_motion();

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(3))
                0:       spd = $urandom_range(1, 40);
                1:       spd = $urandom_range(41, 18000);
                2:       spd = 18000;
                default: spd = 1;
            endcase
            if (p == 5) spd = 0;
            settle_and_write($urandom_range(4000), $urandom_range(4000), spd,
                             (p == 3) ? $urandom_range(20, 40) : $urandom_range(6));
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_BEATS) begin
                pick  = $urandom_range(99);
                reach = int'(move_speed(plan_st)) * int'($urandom_range(1, 20));
                if (pick < 8) begin
                    send_beat($urandom_range(1) ? MODE_UNUSED : MODE_TICK, any_targets());
                end else begin
                    if (reach >= 2 * ANGLE_LIMIT || (pick >= 70 && $urandom_range(1) == 0)) begin
                        tgt = any_targets();
                    end else begin
                        for (int i = 0; i < SERVOS; i++) begin
                            aim = int'($signed(plan_st.start[i])) + int'($urandom_range(2 * reach))
                                  - reach;
                            if (aim > ANGLE_LIMIT) aim = ANGLE_LIMIT;
                            else if (aim < -ANGLE_LIMIT) aim = -ANGLE_LIMIT;
                            tgt[i] = ANGLE_W'(aim);
                        end
                    end
                    if ($urandom_range(19) == 0) tgt = plan_st.start;
                    send_beat((pick < 70) ? MODE_MOVE : MODE_PLACE, tgt);
                    // now and then cut the motion short so later commands hit a busy block
                    cut   = ($urandom_range(9) == 0) ? int'($urandom_range(4)) : -1;
                    steps = 0;
                    while (plan_st.phase != PH_IDLE && steps != cut) begin
                        if ($urandom_range(19) == 0)
                            send_beat($urandom_range(1) ? MODE_MOVE : MODE_PLACE, any_targets());
                        else
                            send_beat(MODE_TICK, any_targets());
                        steps++;
                    end
                end
                if (p == 2 && !paused && phase_items >= PHASE_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        // longest hold, left running at the end
        settle_and_write(0, 4000, 18000, 65535);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        send_beat(MODE_PLACE, any_targets());
        repeat (6) send_beat(MODE_TICK, any_targets());
        send_beat(MODE_MOVE, any_targets());
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && expected_q.size() == 0 && results_owed == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
